// ===== rtl/core/gse_pkg.sv =====
// Shared types, constants and the control program of the Gaussian series evaluator.
// No dependencies; imported by every other file of the block.
package gse_pkg;

   // Fixed field widths
   localparam int X_W      = 18;   // argument
   localparam int TOL_W    = 17;   // tolerance register
   localparam int VAL_W    = 17;   // result value
   localparam int TERMS_W  = 6;    // terms_used and max_terms
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 7;    // term count, reaches 64
   localparam int IDX_W    = 8;    // csr register index
   localparam int DIV_STEP = 4;    // quotient bits per divider cycle
   localparam int STEP_W   = 4;    // program counter

   localparam logic [TOL_W-1:0]   TOL_RESET       = TOL_W'(1);
   localparam logic [TERMS_W-1:0] MAX_TERMS_RESET = TERMS_W'(20);
   localparam logic [TERMS_W-1:0] TERMS_SAT       = '1;

   // csr register indexes
   localparam logic [IDX_W-1:0] REG_TOLERANCE = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_MAX_TERMS = IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_LIMIT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_RANGE,
      OP_SQUARE,
      OP_ACCUM,
      OP_MUL,
      OP_DIV_START,
      OP_DIV_TAKE,
      OP_EMIT_OK,
      OP_EMIT_RANGE,
      OP_EMIT_LIMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_OUT_RANGE,
      COND_OVER_LIMIT,
      COND_BELOW_TOL,
      COND_DIV_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ctrl_type;

   typedef struct packed {
      logic stall;        // hold the program counter
      logic out_range;
      logic over_limit;
      logic below_tol;
      logic div_busy;
   } flags_type;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_LOAD        = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_RANGE       = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_SQUARE      = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_CHECK_LIMIT = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_CHECK_TOL   = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_ACCUM       = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_MUL         = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_DIV_START   = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_DIV_WAIT    = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_DIV_TAKE    = STEP_W'(9);
   localparam logic [STEP_W-1:0] STEP_EMIT_OK     = STEP_W'(10);
   localparam logic [STEP_W-1:0] STEP_EMIT_RANGE  = STEP_W'(11);
   localparam logic [STEP_W-1:0] STEP_EMIT_LIMIT  = STEP_W'(12);

   // Control ROM: jump to target when cond holds, else fall through.
   function automatic ctrl_type prog_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      case (step)
         STEP_LOAD:        w = '{OP_LOAD,       COND_NEVER,      STEP_LOAD};
         STEP_RANGE:       w = '{OP_RANGE,      COND_OUT_RANGE,  STEP_EMIT_RANGE};
         STEP_SQUARE:      w = '{OP_SQUARE,     COND_NEVER,      STEP_LOAD};
         STEP_CHECK_LIMIT: w = '{OP_NOP,        COND_OVER_LIMIT, STEP_EMIT_LIMIT};
         STEP_CHECK_TOL:   w = '{OP_NOP,        COND_BELOW_TOL,  STEP_EMIT_OK};
         STEP_ACCUM:       w = '{OP_ACCUM,      COND_NEVER,      STEP_LOAD};
         STEP_MUL:         w = '{OP_MUL,        COND_NEVER,      STEP_LOAD};
         STEP_DIV_START:   w = '{OP_DIV_START,  COND_NEVER,      STEP_LOAD};
         STEP_DIV_WAIT:    w = '{OP_NOP,        COND_DIV_BUSY,   STEP_DIV_WAIT};
         STEP_DIV_TAKE:    w = '{OP_DIV_TAKE,   COND_ALWAYS,     STEP_CHECK_LIMIT};
         STEP_EMIT_OK:     w = '{OP_EMIT_OK,    COND_ALWAYS,     STEP_LOAD};
         STEP_EMIT_RANGE:  w = '{OP_EMIT_RANGE, COND_ALWAYS,     STEP_LOAD};
         STEP_EMIT_LIMIT:  w = '{OP_EMIT_LIMIT, COND_ALWAYS,     STEP_LOAD};
         default:          w = '{OP_NOP,        COND_ALWAYS,     STEP_LOAD};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/gse_sequencer.sv =====
// Program counter and control ROM of the evaluator.
// Depends on gse_pkg.
module gse_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  gse_pkg::flags_type  flags,
   output gse_pkg::ctrl_type   ctrl
);
   import gse_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take_jump;

   assign ctrl = prog_word(step_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:      take_jump = 1'b0;
         COND_ALWAYS:     take_jump = 1'b1;
         COND_OUT_RANGE:  take_jump = flags.out_range;
         COND_OVER_LIMIT: take_jump = flags.over_limit;
         COND_BELOW_TOL:  take_jump = flags.below_tol;
         COND_DIV_BUSY:   take_jump = flags.div_busy;
         default:         take_jump = 1'b0;
      endcase
   end

   always_comb begin
      if (flags.stall) begin
         step_in = step_ff;
      end else if (take_jump) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/gse_divider.sv =====
// Iterative restoring divider, DIV_STEP quotient bits per cycle, small divisor.
// Depends on gse_pkg.
module gse_divider #(
   parameter int DIVIDEND_W = 17
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIVIDEND_W-1:0]             dividend,
   input  logic [gse_pkg::CNT_W-1:0]         divisor,
   output logic                              busy,
   output logic [DIVIDEND_W-1:0]             quotient
);
   import gse_pkg::*;

   localparam int ITER  = (DIVIDEND_W + DIV_STEP - 1) / DIV_STEP;
   localparam int N     = ITER * DIV_STEP;
   localparam int ITW   = $clog2(ITER + 1);

   logic [N-1:0]       q_ff, q_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   div_ff;
   logic [ITW-1:0]     count_ff;

   // Remainder stays below the divisor (at most 64), so a 7-bit remainder
   // plus one shifted bit covers every partial step.
   always_comb begin
      logic [CNT_W:0] trial;
      rem_in = rem_ff;
      q_in   = q_ff;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {rem_in, q_in[N-1]};
         q_in  = {q_in[N-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial   = trial - {1'b0, div_ff};
            q_in[0] = 1'b1;
         end
         rem_in = trial[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= ITW'(ITER);
      end else if (count_ff != '0) begin
         count_ff <= count_ff - ITW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= N'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (count_ff != '0) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = (count_ff != '0);
   assign quotient = q_ff[DIVIDEND_W-1:0];

endmodule

// ===== rtl/core/gse_datapath.sv =====
// Datapath of the evaluator: config registers, term arithmetic, output register.
// Depends on gse_pkg and gse_divider.
module gse_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gse_pkg::ctrl_type             ctrl,
   output gse_pkg::flags_type            flags,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gse_pkg::IDX_W-1:0]     csr_index,
   input  logic [gse_pkg::TOL_W-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [gse_pkg::X_W-1:0] req_x,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gse_pkg::VAL_W-1:0]     rsp_result,
   output logic [gse_pkg::TERMS_W-1:0]   rsp_terms,
   output gse_pkg::status_type           rsp_status
);
   import gse_pkg::*;

   localparam int W  = FRAC_BITS + 1;                           // term, x^2
   localparam int SW = W + 2;                                   // signed sum
   localparam int XW = (FRAC_BITS + 2 > X_W) ? FRAC_BITS + 2 : X_W;
   localparam int TW = (W > TOL_W) ? W : TOL_W;
   localparam int OW = (SW > VAL_W) ? SW : VAL_W;
   localparam logic [W-1:0]         ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [XW-1:0] ONE_X = XW'(ONE);
   localparam logic signed [SW-1:0] ONE_S = SW'(ONE);

   logic [TOL_W-1:0]       tol_ff;
   logic [TERMS_W-1:0]     max_ff;
   logic signed [X_W-1:0]  x_ff;
   logic [X_W-1:0]         ax_ff;
   logic [W-1:0]           x2_ff, t_ff, p_ff;
   logic signed [SW-1:0]   sum_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   neg_ff;
   logic                   rsp_valid_ff;
   logic [VAL_W-1:0]       rsp_result_ff;
   logic [TERMS_W-1:0]     rsp_terms_ff;
   status_type             rsp_status_ff;

   logic signed [XW-1:0]   x_wide;
   logic [2*X_W-1:0]       sq, sq_sh;
   logic [2*W-1:0]         prod, prod_sh;
   logic signed [SW-1:0]   t_ext;
   logic [OW-1:0]          clamped;
   logic [TERMS_W-1:0]     terms_sat;
   logic [W-1:0]           quot;
   logic                   div_busy;
   logic                   is_emit, out_busy, load_out;

   // ---- config ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         max_ff <= MAX_TERMS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TOLERANCE: tol_ff <= csr_data;
            REG_MAX_TERMS: max_ff <= csr_data[TERMS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- arithmetic ----
   assign x_wide  = XW'(x_ff);
   assign sq      = ax_ff * ax_ff;
   assign sq_sh   = sq >> FRAC_BITS;
   assign prod    = t_ff * x2_ff;
   assign prod_sh = prod >> FRAC_BITS;
   assign t_ext   = SW'(t_ff);

   gse_divider #(.DIVIDEND_W(W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.op == OP_DIV_START),
      .dividend (p_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LOAD: begin
            if (req_valid) begin
               x_ff <= req_x;
            end
         end
         OP_RANGE: begin
            ax_ff <= x_ff[X_W-1] ? (X_W'(~x_ff) + X_W'(1)) : X_W'(x_ff);
         end
         OP_SQUARE: begin
            x2_ff  <= sq_sh[W-1:0];
            t_ff   <= sq_sh[W-1:0];
            sum_ff <= ONE_S;
            cnt_ff <= CNT_W'(1);
            neg_ff <= 1'b1;
         end
         OP_ACCUM: begin
            sum_ff <= neg_ff ? (sum_ff - t_ext) : (sum_ff + t_ext);
            cnt_ff <= cnt_ff + CNT_W'(1);
            neg_ff <= ~neg_ff;
         end
         OP_MUL: begin
            // x^2 of exactly 1.0 leaves the term magnitude unchanged
            p_ff <= (x2_ff >= ONE) ? t_ff : prod_sh[W-1:0];
         end
         OP_DIV_TAKE: begin
            t_ff <= quot;
         end
         default: ;
      endcase
   end

   // ---- flags ----
   assign is_emit  = (ctrl.op == OP_EMIT_OK) || (ctrl.op == OP_EMIT_RANGE)
                     || (ctrl.op == OP_EMIT_LIMIT);
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign load_out = is_emit && !out_busy;

   assign flags.stall      = ((ctrl.op == OP_LOAD) && !req_valid) || (is_emit && out_busy);
   assign flags.out_range  = (x_wide < -ONE_X) || (x_wide > ONE_X);
   assign flags.over_limit = cnt_ff > CNT_W'(max_ff);
   assign flags.below_tol  = TW'(t_ff) < TW'(tol_ff);
   assign flags.div_busy   = div_busy;

   assign req_ready = (ctrl.op == OP_LOAD);

   // ---- output ----
   always_comb begin
      if (sum_ff < 0) begin
         clamped = '0;
      end else if (sum_ff > ONE_S) begin
         clamped = OW'(ONE);
      end else begin
         clamped = OW'(sum_ff);
      end
   end

   assign terms_sat = (cnt_ff > CNT_W'(TERMS_SAT)) ? TERMS_SAT : cnt_ff[TERMS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         case (ctrl.op)
            OP_EMIT_OK: begin
               rsp_result_ff <= clamped[VAL_W-1:0];
               rsp_terms_ff  <= terms_sat;
               rsp_status_ff <= STATUS_OK;
            end
            OP_EMIT_RANGE: begin
               rsp_result_ff <= '0;
               rsp_terms_ff  <= '0;
               rsp_status_ff <= STATUS_RANGE;
            end
            default: begin
               rsp_result_ff <= '0;
               rsp_terms_ff  <= terms_sat;
               rsp_status_ff <= STATUS_LIMIT;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_terms  = rsp_terms_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/core/gaussian_series_evaluator.sv =====
// Top level of the Gaussian series evaluator, exp(-x^2) by its Maclaurin series.
// Depends on gse_pkg, gse_sequencer, gse_datapath (and gse_divider below it).
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   csr     | in        | csr_valid / csr_ready | csr_index (0 tolerance, 1 max_terms),
//           |           |                       | csr_data
//   req     | in        | req_tvalid/req_tready | req_tdata: x_value
//   rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata: result_value, terms_used;
//           |           |                       | rsp_tuser: status
//
// Items: one at a time. An argument out of range goes straight to its emit step. Otherwise
// each added term runs through the control program, which moves one step per cycle
// unless stalled, and the divider, which retires 4 quotient bits per cycle.
// Reset: synchronous, active high; tolerance returns to 1, max_terms to 20, no
// clearing pass. csr_ready is always high.
// Stalls: the result sits in an output register; the next argument is taken while
// it waits, and the sequencer holds on its emit step only if that register is full.
module gaussian_series_evaluator #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [16:0] csr_data,
   // arguments
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // [17:0] x_value, [23:18] zero
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [16:0] result_value, [22:17] terms_used, [23] zero
   output logic [1:0]  rsp_tuser     // [1:0] status
);
   import gse_pkg::*;

   ctrl_type              ctrl;
   flags_type             flags;
   logic [VAL_W-1:0]      result;
   logic [TERMS_W-1:0]    terms;
   status_type            status;

   // program counter and control ROM
   gse_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // registers, multiplier, divider and output register
   gse_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .flags      (flags),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_x      (signed'(req_tdata[X_W-1:0])),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result),
      .rsp_terms  (terms),
      .rsp_status (status)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {1'b0, terms, result};
   assign rsp_tuser = status;

endmodule

// ===== rtl/core/gse_checker.sv =====
// Port-level assertions for the Gaussian series evaluator, bound to the top level.
// Depends on gse_pkg and gaussian_series_evaluator.
module gse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import gse_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one argument at a time: the sequencer leaves its load step after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("argument taken while one is in flight");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_RANGE) |-> (rsp_tdata == '0))
      else $error("range error with nonzero payload");

   a_limit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_LIMIT) |->
         (rsp_tdata[16:0] == '0) && (rsp_tdata[22:17] != '0))
      else $error("limit error with bad payload");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK) || (rsp_tuser == STATUS_RANGE)
                     || (rsp_tuser == STATUS_LIMIT))
      else $error("undefined status code");

endmodule

bind gaussian_series_evaluator gse_checker u_gse_checker (.*);

// ===== verif/tb_gaussian_series_evaluator.sv =====
// Self-checking bench for gaussian_series_evaluator: a directed table, then random phases.
// Expected results come from a series predictor in this file; depends on gse_pkg and the RTL.
module tb_gaussian_series_evaluator;
   timeunit 1ns;
   timeprecision 1ps;

   import gse_pkg::*;

   localparam int     FRAC           = 16;
   localparam longint ONE_FX         = longint'(1) << FRAC;
   localparam int     PHASES         = 10;
   localparam int     ARGS_PER_PHASE = 40;
   localparam int     HOLD_CYCLES    = 300;   // long receiver hold-off, fills the block
   localparam int     TAIL_CYCLES    = 40;    // quiet time after the last result
   localparam int     WATCHDOG_LIMIT = 4000;  // covers the worst item plus the hold-off
   // No register lives here; writes to it must leave both registers alone.
   localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(5);

   // one result as the checker sees it
   typedef struct packed {
      logic [VAL_W-1:0]   value;
      logic [TERMS_W-1:0] terms;
      status_type         status;
   } gauss_result_t;

   // one row of the directed table: a register write or an argument
   typedef struct packed {
      bit                 is_write;
      logic [IDX_W-1:0]   index;
      logic [TOL_W-1:0]   data;
      logic [X_W-1:0]     x;
      bit                 typed;     // expected result typed in below
      gauss_result_t      want;
   } drill_row_t;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [16:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // [17:0] x_value, [23:18] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [16:0] result_value, [22:17] terms_used, [23] zero
   logic [1:0]  rsp_tuser;    // [1:0] status

   gaussian_series_evaluator #(.FRAC_BITS(FRAC)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Predictor's copy of the two registers, updated on each csr transfer.
   logic [TOL_W-1:0]   tol_q;
   logic [TERMS_W-1:0] max_terms_q;

   gauss_result_t gauss_q[$];    // results still owed by the block, oldest first
   drill_row_t    drill[$];

   int  n_errors  = 0;
   int  n_args    = 0;
   int  n_results = 0;
   int  n_writes  = 0;
   int  n_range   = 0;
   int  n_limit   = 0;
   int  quiet     = 0;
   bit  arg_burst = 0;   // sender offers back to back
   bit  rsp_burst = 0;   // receiver always ready
   bit  hold_off  = 0;   // receiver takes one long break at its next result

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor: 1 - x^2 + x^4/2! - ... with truncated fixed-point terms.
   // Each term = (previous * x^2 >> FRAC) / k; stop at the first term under
   // tolerance (not added); the count limit is tested before the tolerance.
   // ------------------------------------------------------------------
   function automatic gauss_result_t eval_gaussian(input logic [X_W-1:0] x_bits);
      longint          x;
      longint          sum;
      longint unsigned mag;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned prod;
      longint unsigned cnt;
      bit              negate;
      bit              done;
      gauss_result_t   r;
      x        = $signed(x_bits);
      r.value  = '0;
      r.terms  = '0;
      r.status = STATUS_RANGE;
      // argument outside [-1.0, 1.0]
      if (x < -ONE_FX || x > ONE_FX) return r;
      mag    = (x < 0) ? -x : x;
      x2     = (mag * mag) >> FRAC;
      sum    = ONE_FX;
      cnt    = 1;
      term   = x2;
      negate = 1'b1;
      done   = 1'b0;
      while (!done) begin
         if (cnt > max_terms_q) begin
            // term limit: count saturates at the field width
            r.terms  = (cnt > 63) ? TERMS_SAT : TERMS_W'(cnt);
            r.status = STATUS_LIMIT;
            return r;
         end else if (term < tol_q) begin
            done = 1'b1;
         end else begin
            sum    = negate ? sum - longint'(term) : sum + longint'(term);
            cnt    = cnt + 1;
            // at |x| = 1 the square is exactly one, the product is the term itself
            prod   = (x2 >= ONE_FX) ? term : (term * x2) >> FRAC;
            term   = prod / cnt;
            negate = !negate;
         end
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_FX) sum = ONE_FX;
      r.value  = VAL_W'(sum);
      r.terms  = TERMS_W'(cnt);
      r.status = STATUS_OK;
      return r;
   endfunction

   // Directed table rows
   function automatic drill_row_t arg_row(input logic [X_W-1:0] x);
      drill_row_t row;
      row   = '0;
      row.x = x;
      return row;
   endfunction

   function automatic drill_row_t known_row(input logic [X_W-1:0] x,
                                            input logic [VAL_W-1:0] value,
                                            input logic [TERMS_W-1:0] terms,
                                            input status_type status);
      drill_row_t row;
      row             = '0;
      row.x           = x;
      row.typed       = 1'b1;
      row.want.value  = value;
      row.want.terms  = terms;
      row.want.status = status;
      return row;
   endfunction

   function automatic drill_row_t write_row(input logic [IDX_W-1:0] index,
                                            input logic [TOL_W-1:0] data);
      drill_row_t row;
      row          = '0;
      row.is_write = 1'b1;
      row.index    = index;
      row.data     = data;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
               $realtime, n_results, what, got, want);
      n_errors++;
   endtask

   // Registers change only with the block empty: every owed result is back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (gauss_q.size() != 0) @(posedge clock);
   endtask

   // Leaves csr_valid high so writes can go back to back; send_arg drops it.
   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [TOL_W-1:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_TOLERANCE)
         tol_q = data;
      else if (index == REG_MAX_TERMS)
         max_terms_q = data[TERMS_W-1:0];
      n_writes++;
   endtask

   // One argument transfer; the expected result is queued at the accepting edge.
   task automatic send_arg(input logic [X_W-1:0] x, input bit typed, input gauss_result_t want);
      int gap;
      gap = arg_burst ? 0 : $urandom_range(0, 15);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'b0, x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gauss_q.push_back(typed ? want : eval_gaussian(x));
      n_args++;
   endtask

   // ------------------------------------------------------------------
   // Result side: random ready gaps, bursts, one long hold-off on request.
   // ------------------------------------------------------------------
   initial begin : collect_results
      int            gap;
      gauss_result_t got;
      gauss_result_t want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            gap      = HOLD_CYCLES;
            hold_off = 1'b0;
         end else if (rsp_burst) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 15);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.value  = rsp_tdata[VAL_W-1:0];
         got.terms  = rsp_tdata[VAL_W +: TERMS_W];
         got.status = status_type'(rsp_tuser);
         n_results++;
         if (got.status == STATUS_RANGE) n_range++;
         if (got.status == STATUS_LIMIT) n_limit++;
         if (gauss_q.size() == 0) begin
            report_mismatch("result with nothing pending, value", got.value, -1);
         end else begin
            want = gauss_q.pop_front();
            if (got.value !== want.value)
               report_mismatch("result_value", got.value, want.value);
            if (got.terms !== want.terms)
               report_mismatch("terms_used", got.terms, want.terms);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
         end
         if (n_results % 25 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // Watchdog: too long without any transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a transfer, %0d results owed",
                  quiet, gauss_q.size());
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : drive_stimulus
      int               pick;
      logic [X_W-1:0]   x;
      logic [TOL_W-1:0] tol_pick;
      logic [TOL_W-1:0] max_pick;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      tol_q       = TOL_RESET;
      max_terms_q = MAX_TERMS_RESET;

      // Directed table. Reset values first: tolerance 1, max_terms 20.
      drill.push_back(known_row(X_W'(0), VAL_W'(ONE_FX), 1, STATUS_OK));
      drill.push_back(arg_row(X_W'(65536)));                  // +1.0, square is one
      drill.push_back(arg_row(X_W'(-65536)));                 // -1.0
      drill.push_back(known_row(X_W'(65537), 0, 0, STATUS_RANGE));
      drill.push_back(known_row(X_W'(-65537), 0, 0, STATUS_RANGE));
      drill.push_back(known_row(X_W'(131071), 0, 0, STATUS_RANGE));
      drill.push_back(known_row(X_W'(-131072), 0, 0, STATUS_RANGE));
      // smallest magnitudes: square truncates to zero
      drill.push_back(known_row(X_W'(1), VAL_W'(ONE_FX), 1, STATUS_OK));
      drill.push_back(known_row(X_W'(-1), VAL_W'(ONE_FX), 1, STATUS_OK));
      drill.push_back(arg_row(X_W'(32768)));
      drill.push_back(arg_row(X_W'(-12345)));
      drill.push_back(arg_row(X_W'(65535)));
      // zero max_terms: limit on the very first term
      drill.push_back(write_row(REG_MAX_TERMS, 0));
      drill.push_back(known_row(X_W'(0), 0, 1, STATUS_LIMIT));
      drill.push_back(known_row(X_W'(65537), 0, 0, STATUS_RANGE));   // range wins
      // zero tolerance never converges; count runs past 63 and saturates
      drill.push_back(write_row(REG_TOLERANCE, 0));
      drill.push_back(write_row(REG_MAX_TERMS, 63));
      drill.push_back(known_row(X_W'(0), 0, TERMS_SAT, STATUS_LIMIT));
      drill.push_back(known_row(X_W'(-65536), 0, TERMS_SAT, STATUS_LIMIT));
      // largest tolerance: first term below it unless |x| = 1
      drill.push_back(write_row(REG_TOLERANCE, TOL_W'(ONE_FX)));
      drill.push_back(write_row(REG_MAX_TERMS, 20));
      drill.push_back(known_row(X_W'(16384), VAL_W'(ONE_FX), 1, STATUS_OK));
      drill.push_back(arg_row(X_W'(65536)));
      // write to an unused index, tolerance must still be 1.0
      drill.push_back(write_row(REG_UNUSED, 3));
      drill.push_back(known_row(X_W'(100), VAL_W'(ONE_FX), 1, STATUS_OK));
      // upper data bits of a max_terms write are dropped: 0x10002 -> 2
      drill.push_back(write_row(REG_TOLERANCE, 1));
      drill.push_back(write_row(REG_MAX_TERMS, TOL_W'(17'h10002)));
      drill.push_back(arg_row(X_W'(65536)));
      drill.push_back(write_row(REG_MAX_TERMS, 20));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (drill[i]) begin
         if (drill[i].is_write) begin
            wait_drained();
            write_reg(drill[i].index, drill[i].data);
         end else begin
            send_arg(drill[i].x, drill[i].typed, drill[i].want);
         end
      end

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         if (phase == 0) begin
            // extremes together: widest tolerance, largest count
            tol_pick = TOL_W'(ONE_FX);
            max_pick = 63;
         end else begin
            case ($urandom_range(0, 5))
               0:       tol_pick = 0;
               1:       tol_pick = 1;
               2:       tol_pick = $urandom_range(2, 255);
               3:       tol_pick = $urandom_range(0, 65536);
               4:       tol_pick = TOL_W'(ONE_FX);
               default: tol_pick = TOL_W'($urandom);   // above 1.0 too
            endcase
            case ($urandom_range(0, 4))
               0:       max_pick = $urandom_range(0, 63);
               1:       max_pick = 20;
               2:       max_pick = 63;
               3:       max_pick = $urandom_range(0, 5);
               default: max_pick = TOL_W'($urandom);   // junk in the upper bits
            endcase
         end
         if ($urandom_range(0, 1)) begin
            write_reg(REG_TOLERANCE, tol_pick);
            write_reg(REG_MAX_TERMS, max_pick);
         end else begin
            write_reg(REG_MAX_TERMS, max_pick);
            if ($urandom_range(0, 3) == 0) write_reg(IDX_W'($urandom_range(2, 255)), $urandom);
            write_reg(REG_TOLERANCE, tol_pick);
         end

         arg_burst = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            // receiver stalls long while arguments keep coming
            arg_burst = 1'b1;
            hold_off  = 1'b1;
         end

         for (int n = 0; n < ARGS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               x = X_W'($urandom_range(0, 131072) - 65536);
            end else if (pick < 80) begin
               case ($urandom_range(0, 7))
                  0:       x = X_W'(0);
                  1:       x = X_W'(1);
                  2:       x = X_W'(-1);
                  3:       x = X_W'(65536);
                  4:       x = X_W'(-65536);
                  5:       x = X_W'(65535);
                  6:       x = X_W'(-65537);
                  default: x = X_W'(65537);
               endcase
            end else begin
               x = X_W'($urandom);
            end
            send_arg(x, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d arguments through %0d register writes; %0d results checked,",
               n_args, n_writes, n_results);
      $display("%0d of them out of range and %0d at the term limit.", n_range, n_limit);
      if (n_errors == 0 && gauss_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results never arrived", n_errors, gauss_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
